// ===== sv/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text terminal cell writer: screen size,
// cell layout, character codes, command modes and the sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam int COPY_COUNT = COLUMNS * (ROWS - 1);
	localparam int TAB_STOP   = 8;

	localparam int COL_W  = $clog2(COLUMNS);
	localparam int COLX_W = COL_W + 1;
	localparam int ROW_W  = $clog2(ROWS);
	localparam int ROWX_W = ROW_W + 1;
	localparam int ADDR_W = $clog2(CELL_COUNT);
	localparam int CELL_W = 16;

	localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0020;

	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TILDE = 8'h7E;

	localparam logic [1:0] MODE_PRINT = 2'd0;
	localparam logic [1:0] MODE_CLEAR = 2'd1;
	localparam logic [1:0] MODE_READ  = 2'd2;

	typedef struct packed {
		logic [1:0]  mode;
		logic [7:0]  char_code;
		logic [3:0]  fore_color;
		logic [3:0]  back_color;
		logic [10:0] cell_address;
	} tcw_in_t;

	typedef struct packed {
		logic [6:0]  cursor_col;
		logic [4:0]  cursor_row;
		logic [15:0] cell_data;
	} tcw_out_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_INIT_END,
		ST_IDLE,
		ST_READ,
		ST_SCROLL,
		ST_FILL,
		ST_FLUSH
	} tcw_state_t;

endpackage

`default_nettype wire

// ===== sv/text_terminal_cell_writer.sv =====
// ----------------------------------------------------------------------------
// text_terminal_cell_writer
// Text-mode terminal engine: 80x25 screen of 16-bit cells in one RAM, cursor
// handling, wrap, scroll, clear and cell read-back, run by a small sequencer.
// ----------------------------------------------------------------------------
//  channel  | handshake      | payload            | accepted when
//  command  | start / busy   | cmd    (tcw_in_t)  | start high and busy low
//  result   | done (strobe)  | result (tcw_out_t) | every cycle done is high
//
//  print without scroll, control code, unused mode: result in the cycle after the command
//  read: inside the screen through ST_READ (registered RAM read port), outside straight from ST_IDLE
//  scroll: one RAM read and one write per cycle, then the bottom row is blanked
//  clear: one blank write per cycle
//  after reset busy stays high while the RAM is blanked; results are shown
//  for one cycle only and cannot be held off
// ----------------------------------------------------------------------------
`default_nettype none

module text_terminal_cell_writer
	import tcw_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	output logic          busy,
	input  wire tcw_in_t  cmd,
	output logic          done,
	output tcw_out_t      result
);

	tcw_state_t state_q, state_d;

	logic [ADDR_W-1:0] idx_q, idx_d;
	logic [COL_W-1:0]  col_q, col_d;
	logic [ROW_W-1:0]  row_q, row_d;

	// write stage behind the RAM read for the copy and blank sweeps
	logic              wr_vld_s1;
	logic              wr_blank_s1;
	logic [ADDR_W-1:0] wr_idx_s1;

	logic     done_q;
	tcw_out_t res_q;

	logic              issue, issue_blank;
	logic              fin;
	logic [CELL_W-1:0] fin_data;

	logic              print_we;
	logic [ADDR_W-1:0] print_waddr;
	logic [CELL_W-1:0] print_wdata;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [CELL_W-1:0] ram_wdata, ram_rdata;

	logic              accept;
	logic [COLX_W-1:0] col_t;
	logic [ROWX_W-1:0] row_t;
	logic              printable;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = res_q;

	assign printable   = cmd.char_code inside {[CH_SPACE:CH_TILDE]};
	assign print_waddr = ADDR_W'(ADDR_W'(row_q) * ADDR_W'(COLUMNS)) + ADDR_W'(col_q);
	assign print_wdata = {cmd.back_color, cmd.fore_color, cmd.char_code};

	// cursor step for a print item
	always_comb begin
		col_t = COLX_W'(col_q);
		row_t = ROWX_W'(row_q);
		case (cmd.char_code)
			CH_BS: begin
				if (col_q != '0) begin
					col_t = COLX_W'(col_q) - COLX_W'(1);
				end
			end
			CH_LF: begin
				col_t = '0;
				row_t = ROWX_W'(row_q) + ROWX_W'(1);
			end
			CH_CR: begin
				col_t = '0;
			end
			CH_TAB: begin
				col_t = (COLX_W'(col_q) + COLX_W'(TAB_STOP)) & ~COLX_W'(TAB_STOP - 1);
			end
			default: begin
				if (printable) begin
					col_t = COLX_W'(col_q) + COLX_W'(1);
				end
			end
		endcase
		if (col_t >= COLX_W'(COLUMNS)) begin
			col_t = '0;
			row_t = row_t + ROWX_W'(1);
		end
	end

	always_comb begin
		state_d     = state_q;
		idx_d       = idx_q;
		col_d       = col_q;
		row_d       = row_q;
		ram_raddr   = cmd.cell_address[ADDR_W-1:0];
		issue       = 1'b0;
		issue_blank = 1'b0;
		print_we    = 1'b0;
		fin         = 1'b0;
		fin_data    = '0;
		case (state_q)
			ST_INIT, ST_FILL: begin
				issue       = 1'b1;
				issue_blank = 1'b1;
				if (idx_q == ADDR_W'(CELL_COUNT - 1)) begin
					state_d = (state_q == ST_INIT) ? ST_INIT_END : ST_FLUSH;
				end else begin
					idx_d = idx_q + ADDR_W'(1);
				end
			end
			ST_INIT_END: begin
				state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					case (cmd.mode)
						MODE_PRINT: begin
							print_we = printable;
							col_d    = COL_W'(col_t);
							if (row_t >= ROWX_W'(ROWS)) begin
								row_d   = ROW_W'(ROWS - 1);
								idx_d   = '0;
								state_d = ST_SCROLL;
							end else begin
								row_d = ROW_W'(row_t);
								fin   = 1'b1;
							end
						end
						MODE_CLEAR: begin
							col_d   = '0;
							row_d   = '0;
							idx_d   = '0;
							state_d = ST_FILL;
						end
						MODE_READ: begin
							if (32'(cmd.cell_address) < CELL_COUNT) begin
								state_d = ST_READ;
							end else begin
								fin = 1'b1;
							end
						end
						default: begin
							fin = 1'b1;
						end
					endcase
				end
			end
			ST_READ: begin
				fin      = 1'b1;
				fin_data = ram_rdata;
				state_d  = ST_IDLE;
			end
			ST_SCROLL: begin
				ram_raddr = idx_q + ADDR_W'(COLUMNS);
				issue     = 1'b1;
				if (idx_q == ADDR_W'(COPY_COUNT - 1)) begin
					state_d = ST_FILL;
				end
				idx_d = idx_q + ADDR_W'(1);
			end
			ST_FLUSH: begin
				fin     = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// the sweep write stage and a print write never fall in the same cycle
	assign ram_we    = wr_vld_s1 || print_we;
	assign ram_waddr = wr_vld_s1 ? wr_idx_s1 : print_waddr;
	assign ram_wdata = wr_vld_s1 ? (wr_blank_s1 ? BLANK_CELL : ram_rdata) : print_wdata;

	tcw_ram #(
		.WIDTH (CELL_W),
		.DEPTH (CELL_COUNT)
	) u_screen (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_INIT;
			idx_q     <= '0;
			col_q     <= '0;
			row_q     <= '0;
			wr_vld_s1 <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			idx_q     <= idx_d;
			col_q     <= col_d;
			row_q     <= row_d;
			wr_vld_s1 <= issue;
			done_q    <= fin;
		end
	end

	always_ff @(posedge clk) begin
		wr_blank_s1 <= issue_blank;
		wr_idx_s1   <= idx_q;
		if (fin) begin
			res_q.cursor_col <= 7'(col_d);
			res_q.cursor_row <= 5'(row_d);
			res_q.cell_data  <= fin_data;
		end
	end

endmodule

`default_nettype wire

// ===== sv/tcw_ram.sv =====
// ----------------------------------------------------------------------------
// tcw_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== sv/tcw_checker.sv =====
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks of the text terminal cell writer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_checker
	import tcw_pkg::*;
(
	input wire logic     clk,
	input wire logic     arst_n,
	input wire logic     start,
	input wire logic     busy,
	input wire tcw_in_t  cmd,
	input wire logic     done,
	input wire tcw_out_t result
);

	// an accepted item either answers at once or holds the block busy
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done)
		else $error("accepted item neither answered nor started a sequence");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while the sequencer is still busy");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (32'(result.cursor_col) < COLUMNS) && (32'(result.cursor_row) < ROWS))
		else $error("cursor outside the screen");

	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy raised without an item");

	a_clear_walks: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (cmd.mode == MODE_CLEAR) |=> busy && !done)
		else $error("clear item did not start the blanking sweep");

endmodule

bind text_terminal_cell_writer tcw_checker u_tcw_checker (.*);

`default_nettype wire

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for text_terminal_cell_writer. A predictor keeps its own
// screen and cursor and works out the result of every accepted command; a
// checker compares each done strobe against the oldest prediction. Directed
// commands first, then random text, control codes, reads and noise.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tcw_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 4_000_000;
	localparam int unsigned MAX_REPORTS  = 10;
	localparam int unsigned TAIL_CYCLES  = 20;
	localparam int unsigned RANDOM_ITEMS = 470;
	localparam int unsigned FINAL_ITEMS  = 60;
	localparam int unsigned ADDR_TOP     = 2047;

	localparam logic [1:0] MODE_UNUSED = 2'd3;

	localparam logic [7:0] CH_NUL      = 8'h00;
	localparam logic [7:0] CH_US       = 8'h1F;
	localparam logic [7:0] CH_LETTER_A = 8'h41;
	localparam logic [7:0] CH_DEL      = 8'h7F;
	localparam logic [7:0] CH_TOP      = 8'hFF;

	logic     clk    = 1'b0;
	logic     arst_n = 1'b0;
	logic     start  = 1'b0;
	tcw_in_t  cmd    = '0;
	logic     busy;
	logic     done;
	tcw_out_t result;

	// predicted terminal state
	logic [CELL_W-1:0] screen_model [CELL_COUNT];
	int unsigned       cur_col;
	int unsigned       cur_row;

	tcw_out_t    expected_results [$];
	int unsigned mismatch_count = 0;
	int unsigned cycle_count    = 0;
	int unsigned counted_items  = 0;
	bit          idle_on        = 1'b0;

	text_terminal_cell_writer i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic bit is_printable(logic [7:0] code);
		return code >= CH_SPACE && code <= CH_TILDE;
	endfunction

	function automatic bit is_ignored(tcw_in_t c);
		if (c.mode == MODE_UNUSED)
			return 1'b1;
		if (c.mode != MODE_PRINT)
			return 1'b0;
		return !(is_printable(c.char_code) || c.char_code == CH_BS || c.char_code == CH_LF ||
			c.char_code == CH_CR || c.char_code == CH_TAB);
	endfunction

	function automatic void blank_screen_model();
		for (int k = 0; k < CELL_COUNT; k++)
			screen_model[k] = BLANK_CELL;
	endfunction

	function automatic void scroll_screen_model();
		for (int k = 0; k < COPY_COUNT; k++)
			screen_model[k] = screen_model[k + COLUMNS];
		for (int k = COPY_COUNT; k < CELL_COUNT; k++)
			screen_model[k] = BLANK_CELL;
	endfunction

	function automatic tcw_out_t terminal_step(tcw_in_t c);
		tcw_out_t    res;
		int unsigned at;
		res = '0;
		case (c.mode)
			MODE_PRINT: begin
				if (c.char_code == CH_BS) begin
					if (cur_col > 0)
						cur_col--;
				end else if (c.char_code == CH_LF) begin
					cur_col = 0;
					cur_row++;
				end else if (c.char_code == CH_CR) begin
					cur_col = 0;
				end else if (c.char_code == CH_TAB) begin
					cur_col = (cur_col + TAB_STOP) & ~(TAB_STOP - 1);
				end else if (is_printable(c.char_code)) begin
					at = cur_row * COLUMNS + cur_col;
					if (at < CELL_COUNT)
						screen_model[at] = {c.back_color, c.fore_color, c.char_code};
					cur_col++;
				end
				// wrap, then scroll when the bottom row is passed
				if (cur_col >= COLUMNS) begin
					cur_col = 0;
					cur_row++;
				end
				if (cur_row >= ROWS) begin
					scroll_screen_model();
					cur_row = ROWS - 1;
				end
			end
			MODE_CLEAR: begin
				blank_screen_model();
				cur_col = 0;
				cur_row = 0;
			end
			MODE_READ: begin
				if (c.cell_address < CELL_COUNT)
					res.cell_data = screen_model[c.cell_address];
			end
			default: ;
		endcase
		res.cursor_col = 7'(cur_col);
		res.cursor_row = 5'(cur_row);
		return res;
	endfunction

	function automatic tcw_in_t make_item(logic [1:0] mode, logic [7:0] code,
		logic [3:0] fore, logic [3:0] back, logic [10:0] addr);
		tcw_in_t c;
		c.mode         = mode;
		c.char_code    = code;
		c.fore_color   = fore;
		c.back_color   = back;
		c.cell_address = addr;
		return c;
	endfunction

	function automatic tcw_in_t random_print(logic [7:0] code);
		return make_item(MODE_PRINT, code, 4'($urandom), 4'($urandom), 11'($urandom));
	endfunction

	// holds start high until the item is taken; start stays high on return
	task automatic send_item(input tcw_in_t item);
		start <= 1'b1;
		cmd   <= item;
		do @(posedge clk); while (busy !== 1'b0);
		expected_results.push_back(terminal_step(item));
	endtask

	task automatic idle_cycles(input int unsigned n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic wait_for_results();
		start <= 1'b0;
		do @(posedge clk); while (expected_results.size() != 0);
	endtask

	task automatic send_counted(input tcw_in_t item, input bit allow_idle);
		send_item(item);
		if (!is_ignored(item))
			counted_items++;
		if (allow_idle && idle_on && $urandom_range(0, 2) == 0)
			idle_cycles($urandom_range(1, 6));
	endtask

	task automatic run_traffic(input int unsigned target, input bit allow_idle);
		int unsigned pick;
		int unsigned len;
		int unsigned addr;
		logic [3:0]  fg;
		logic [3:0]  bg;
		logic [7:0]  code;
		tcw_in_t     item;
		counted_items = 0;
		while (counted_items < target) begin
			idle_on = allow_idle && $urandom_range(0, 9) < 7;
			pick    = $urandom_range(0, 99);
			if (pick < 40) begin
				// a line of text, now and then long enough to wrap
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 100) : $urandom_range(1, 30);
				fg  = 4'($urandom);
				bg  = 4'($urandom);
				repeat (len) begin
					if ($urandom_range(0, 4) == 0) begin
						fg = 4'($urandom);
						bg = 4'($urandom);
					end
					item            = random_print(8'($urandom_range(CH_SPACE, CH_TILDE)));
					item.fore_color = fg;
					item.back_color = bg;
					send_counted(item, allow_idle);
				end
				pick = $urandom_range(0, 9);
				if (pick < 2)
					send_counted(random_print(CH_CR), allow_idle);
				if (pick < 7)
					send_counted(random_print(CH_LF), allow_idle);
			end else if (pick < 55) begin
				repeat ($urandom_range(1, 6))
					send_counted(random_print(CH_LF), allow_idle);
			end else if (pick < 70) begin
				repeat ($urandom_range(1, 4)) begin
					if ($urandom_range(0, 1) == 0)
						addr = $urandom_range(0, cur_row * COLUMNS + COLUMNS - 1);
					else
						addr = $urandom_range(0, ADDR_TOP);
					item      = random_print(8'($urandom));
					item.mode = MODE_READ;
					item.cell_address = 11'(addr);
					send_counted(item, allow_idle);
				end
			end else if (pick < 85) begin
				repeat ($urandom_range(1, 6)) begin
					case ($urandom_range(0, 4))
						0:       code = CH_BS;
						1:       code = CH_TAB;
						2:       code = CH_CR;
						3:       code = CH_LF;
						default: code = 8'($urandom_range(CH_SPACE, CH_TILDE));
					endcase
					send_counted(random_print(code), allow_idle);
				end
			end else begin
				// any byte in any mode; clears are kept rare
				repeat ($urandom_range(1, 5)) begin
					item = random_print(8'($urandom));
					item.mode = 2'($urandom);
					if (item.mode == MODE_CLEAR && $urandom_range(0, 9) != 0)
						item.mode = MODE_PRINT;
					send_counted(item, allow_idle);
				end
			end
		end
	endtask

	task automatic test_print_codes();
		send_item(make_item(MODE_READ, CH_NUL, 4'h0, 4'h0, 11'd0));
		send_item(make_item(MODE_PRINT, CH_LETTER_A, 4'hF, 4'h0, 11'd0));
		send_item(make_item(MODE_PRINT, CH_SPACE, 4'h0, 4'hF, 11'h7FF));
		send_item(make_item(MODE_PRINT, CH_TILDE, 4'h5, 4'hA, 11'h555));
		send_item(make_item(MODE_PRINT, CH_US, 4'hF, 4'hF, 11'd0));
		send_item(make_item(MODE_PRINT, CH_DEL, 4'hF, 4'hF, 11'd0));
		send_item(make_item(MODE_PRINT, CH_TOP, 4'hF, 4'hF, 11'd0));
		send_item(make_item(MODE_PRINT, CH_NUL, 4'h0, 4'h0, 11'd0));
		for (int k = 0; k < 3; k++)
			send_item(make_item(MODE_READ, CH_NUL, 4'h0, 4'h0, 11'(k)));
	endtask

	task automatic test_cursor_controls();
		send_item(make_item(MODE_PRINT, CH_BS, 4'h0, 4'h0, 11'd0));
		send_item(make_item(MODE_PRINT, CH_CR, 4'h0, 4'h0, 11'd0));
		// backspace at column zero stays put
		send_item(make_item(MODE_PRINT, CH_BS, 4'h0, 4'h0, 11'd0));
		send_item(make_item(MODE_PRINT, CH_TAB, 4'h0, 4'h0, 11'd0));
		send_item(make_item(MODE_PRINT, CH_LETTER_A, 4'h3, 4'hC, 11'd0));
		send_item(make_item(MODE_PRINT, CH_TAB, 4'h0, 4'h0, 11'd0));
		send_item(make_item(MODE_PRINT, CH_LF, 4'h0, 4'h0, 11'd0));
		send_item(make_item(MODE_UNUSED, CH_TOP, 4'hF, 4'hF, 11'h7FF));
	endtask

	task automatic test_read_and_clear();
		send_item(make_item(MODE_READ, CH_NUL, 4'h0, 4'h0, 11'(CELL_COUNT - 1)));
		send_item(make_item(MODE_READ, CH_NUL, 4'h0, 4'h0, 11'(CELL_COUNT)));
		send_item(make_item(MODE_READ, CH_TOP, 4'hF, 4'hF, 11'(ADDR_TOP)));
		send_item(make_item(MODE_CLEAR, CH_NUL, 4'h0, 4'h0, 11'd0));
		send_item(make_item(MODE_READ, CH_NUL, 4'h0, 4'h0, 11'd8));
	endtask

	task automatic test_random_traffic();
		run_traffic(RANDOM_ITEMS / 2, 1'b1);
		// let the block drain completely before carrying on
		wait_for_results();
		run_traffic(RANDOM_ITEMS / 2, 1'b1);
	endtask

	task automatic test_back_to_back();
		run_traffic(FINAL_ITEMS, 1'b0);
	endtask

	always @(posedge clk) begin : check_results
		tcw_out_t want;
		if (done === 1'b1) begin
			if (expected_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("%0t: unexpected result col %0d row %0d data %h", $time,
						result.cursor_col, result.cursor_row, result.cell_data);
			end else begin
				want = expected_results.pop_front();
				if (result.cursor_col !== want.cursor_col || result.cursor_row !== want.cursor_row ||
					result.cell_data !== want.cell_data) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("%0t: expected col %0d row %0d data %h, got col %0d row %0d data %h",
							$time, want.cursor_col, want.cursor_row, want.cell_data,
							result.cursor_col, result.cursor_row, result.cell_data);
				end
			end
		end
	end

	initial begin
		blank_screen_model();
		cur_col = 0;
		cur_row = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_print_codes();
		test_cursor_controls();
		test_read_and_clear();
		wait_for_results();
		test_random_traffic();
		wait_for_results();
		test_back_to_back();
		wait_for_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_results.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
